@@ design/akvt_pkg.sv @@
package akvt_pkg;

  localparam int unsigned MAX_VALUE_BYTES = 255;
  localparam int unsigned MAX_LINE_BYTES  = 2047;
  localparam int unsigned VLEN_W = $clog2(MAX_VALUE_BYTES + 1);
  localparam int unsigned LLEN_W = $clog2(MAX_LINE_BYTES + 1);

  localparam int unsigned NKEYS  = 10;
  localparam int unsigned KLEN_W = 4;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_EQ    = 8'd61;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_VEND  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP     = 3'd0,
    PH_KEY      = 3'd1,
    PH_TOKSKIP  = 3'd2,
    PH_VSTART   = 3'd3,
    PH_UNQUOTED = 3'd4,
    PH_QUOTED   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] key_class;
    logic [7:0] value_byte;
    logic       last;
  } res_t;

  // key text, first character in the top byte
  localparam logic [NKEYS-1:0][63:0] KEY_TEXT = {
    {"GID", 40'h0}, {"gid", 40'h0}, {"UID", 40'h0}, {"uid", 40'h0},
    {"AUID", 32'h0}, {"auid", 32'h0}, {"success", 8'h0},
    {"key", 40'h0}, {"exe", 40'h0}, {"type", 32'h0}
  };

  localparam logic [NKEYS-1:0][KLEN_W-1:0] KEY_LEN = {
    4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd7, 4'd3, 4'd3, 4'd4
  };

  localparam logic [NKEYS-1:0][2:0] KEY_CLS = {
    3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };

  function automatic logic [7:0] key_char(input int unsigned k, input logic [2:0] idx);
    logic [63:0] w;
    w = KEY_TEXT[k];
    return w[63 - 8 * idx -: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

endpackage

@@ design/audit_key_value_tokenizer.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_text_byte[7:0], in_buffer_end
// out_      output     out_valid / out_ready  out_kind[1:0], out_key_class[2:0],
//                                             out_value_byte[7:0], out_last
//
// Each byte is parsed in the cycle it is accepted; its zero to three result
// words enter a four-word result queue and leave one per cycle while out_ready is high.
// One byte per cycle while each byte yields at most one word and out_ready is high;
// a byte that yields more words holds the input while the single output port drains them.
// in_ready is high while the queue holds at most one word, so a stall on the
// output side backs up to the input.
// Synchronous active-low reset clears the parse state and empties the queue.
module audit_key_value_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [2:0] out_key_class,
  output logic [7:0] out_value_byte,
  output logic       out_last
);
  import akvt_pkg::*;

  phase_t                  phase_r, phase_nxt, phase_h;
  logic [NKEYS-1:0]        match_r, match_nxt, match_h;
  logic [KLEN_W-1:0]       klen_r, klen_nxt, klen_h;
  logic                    quote_sq_r, quote_sq_nxt, quote_sq_h;
  logic [VLEN_W-1:0]       vlen_r, vlen_nxt, vlen_h;
  logic [2:0]              cls_r, cls_nxt, cls_h;
  logic                    rec_r, rec_nxt, rec_h;
  logic                    nonblank_r, nonblank_nxt, nonblank_h;
  logic [LLEN_W-1:0]       llen_r, llen_nxt, llen_h;

  res_t                    q_r [QDEPTH];
  logic [QAW-1:0]          wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]          count_r, count_nxt;

  logic                    accept, pop;
  logic [7:0]              c;
  logic                    is_nl, blank, is_quote, close, hb_active;
  logic [7:0]              close_q;
  logic                    hb_vbyte, hb_vend, key_fin, key_feed, key_begin;
  logic                    rec_fin;
  logic [2:0]              cls_fin;
  logic [NKEYS-1:0]        feed_base, feed_bits;
  logic [KLEN_W-1:0]       feed_len;
  logic                    emit0, emit1, emit2;
  res_t                    res [3];
  logic [1:0]              n_res;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = count_r <= QCW'(QDEPTH - 3);
  assign out_valid = count_r != '0;

  assign out_kind       = q_r[rd_ptr_r].kind;
  assign out_key_class  = q_r[rd_ptr_r].key_class;
  assign out_value_byte = q_r[rd_ptr_r].value_byte;
  assign out_last       = q_r[rd_ptr_r].last;

  assign c         = in_text_byte;
  assign is_nl     = c == CH_NL;
  assign blank     = is_blank(c);
  assign is_quote  = c inside {CH_DQ, CH_SQ};
  assign close     = is_nl || in_buffer_end;
  assign hb_active = !is_nl && (llen_r < LLEN_W'(MAX_LINE_BYTES));
  assign close_q   = quote_sq_r ? CH_SQ : CH_DQ;

  assign hb_vend = hb_active && (
      (phase_r == PH_VSTART && !is_quote && blank) ||
      (phase_r == PH_UNQUOTED && blank) ||
      (phase_r == PH_QUOTED && c == close_q));
  assign hb_vbyte = hb_active && (
      (phase_r == PH_VSTART && !is_quote && !blank) ||
      (phase_r == PH_UNQUOTED && !blank) ||
      (phase_r == PH_QUOTED && c != close_q));
  assign key_fin   = hb_active && phase_r == PH_KEY && c == CH_EQ;
  assign key_begin = hb_active && phase_r == PH_SKIP && !blank && c != CH_EQ;
  assign key_feed  = key_begin || (hb_active && phase_r == PH_KEY && c != CH_EQ);

  assign feed_base = key_begin ? '1 : match_r;
  assign feed_len  = key_begin ? '0 : klen_r;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      feed_bits[k] = feed_base[k] && (feed_len < KEY_LEN[k]) &&
                     (key_char(k, feed_len[2:0]) == c);
    end
  end

  always_comb begin
    rec_fin = 1'b0;
    cls_fin = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (match_r[k] && klen_r == KEY_LEN[k]) begin
        rec_fin = 1'b1;
        cls_fin = KEY_CLS[k];
      end
    end
  end

  // state after the byte itself, before any line close
  always_comb begin
    phase_h    = phase_r;
    quote_sq_h = quote_sq_r;
    if (hb_active) begin
      case (phase_r)
        PH_SKIP: begin
          if (!blank) phase_h = (c == CH_EQ) ? PH_TOKSKIP : PH_KEY;
        end
        PH_KEY: begin
          if (c == CH_EQ) phase_h = PH_VSTART;
        end
        PH_TOKSKIP: begin
          if (blank) phase_h = PH_SKIP;
        end
        PH_VSTART: begin
          if (is_quote) begin
            phase_h    = PH_QUOTED;
            quote_sq_h = c == CH_SQ;
          end else if (blank) begin
            phase_h = PH_SKIP;
          end else begin
            phase_h = PH_UNQUOTED;
          end
        end
        PH_UNQUOTED: begin
          if (blank) phase_h = PH_SKIP;
        end
        PH_QUOTED: begin
          if (c == close_q) phase_h = PH_SKIP;
        end
        default: phase_h = PH_SKIP;
      endcase
    end
  end

  always_comb begin
    match_h = key_feed ? feed_bits : match_r;
    if (key_feed) klen_h = (feed_len == '1) ? feed_len : feed_len + 1'b1;
    else          klen_h = klen_r;
    if (key_fin || hb_vend)                               vlen_h = '0;
    else if (hb_vbyte && vlen_r < VLEN_W'(MAX_VALUE_BYTES)) vlen_h = vlen_r + 1'b1;
    else                                                  vlen_h = vlen_r;
    rec_h      = key_fin ? rec_fin : (hb_vend ? 1'b0 : rec_r);
    cls_h      = key_fin ? cls_fin : cls_r;
    nonblank_h = nonblank_r || (hb_active && !blank);
    llen_h     = hb_active ? llen_r + 1'b1 : llen_r;
  end

  always_comb begin
    if (close) begin
      phase_nxt    = PH_SKIP;
      match_nxt    = '1;
      klen_nxt     = '0;
      quote_sq_nxt = 1'b0;
      vlen_nxt     = '0;
      cls_nxt      = '0;
      rec_nxt      = 1'b0;
      nonblank_nxt = 1'b0;
      llen_nxt     = '0;
    end else begin
      phase_nxt    = phase_h;
      match_nxt    = match_h;
      klen_nxt     = klen_h;
      quote_sq_nxt = quote_sq_h;
      vlen_nxt     = vlen_h;
      cls_nxt      = cls_h;
      rec_nxt      = rec_h;
      nonblank_nxt = nonblank_h;
      llen_nxt     = llen_h;
    end
  end

  // result words for the byte
  assign emit0 = rec_r && ((hb_vbyte && vlen_r < VLEN_W'(MAX_VALUE_BYTES)) || hb_vend);
  assign emit1 = close && rec_h && (phase_h inside {PH_VSTART, PH_UNQUOTED, PH_QUOTED});
  assign emit2 = close && nonblank_h;

  always_comb begin
    for (int i = 0; i < 3; i++) res[i] = '0;
    n_res = '0;
    if (emit0) begin
      res[n_res].kind       = hb_vend ? KIND_VEND : KIND_BYTE;
      res[n_res].key_class  = cls_r;
      res[n_res].value_byte = hb_vend ? 8'd0 : c;
      n_res = n_res + 1'b1;
    end
    if (emit1) begin
      res[n_res].kind      = KIND_VEND;
      res[n_res].key_class = cls_h;
      n_res = n_res + 1'b1;
    end
    if (emit2) begin
      res[n_res].kind = KIND_EVENT;
      n_res = n_res + 1'b1;
    end
    if (n_res != '0) res[n_res - 1'b1].last = 1'b1;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(n_res);
      count_nxt  = count_r + QCW'(n_res);
    end
    if (pop) count_nxt = count_nxt - 1'b1;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      match_r    <= '1;
      klen_r     <= '0;
      quote_sq_r <= 1'b0;
      vlen_r     <= '0;
      cls_r      <= '0;
      rec_r      <= 1'b0;
      nonblank_r <= 1'b0;
      llen_r     <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        match_r    <= match_nxt;
        klen_r     <= klen_nxt;
        quote_sq_r <= quote_sq_nxt;
        vlen_r     <= vlen_nxt;
        cls_r      <= cls_nxt;
        rec_r      <= rec_nxt;
        nonblank_r <= nonblank_nxt;
        llen_r     <= llen_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (i < int'(n_res)) q_r[wr_ptr_r + QAW'(i)] <= res[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_vlen_bound : assert property (@(posedge clk) disable iff (!rst_n)
    vlen_r <= VLEN_W'(MAX_VALUE_BYTES))
    else $error("value length past limit");

  a_close_resets : assert property (@(posedge clk) disable iff (!rst_n)
    accept && close |=> phase_r == PH_SKIP && llen_r == '0 && !nonblank_r)
    else $error("line close left parse state");

  a_event_queued : assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_nl && nonblank_r |=> out_valid)
    else $error("line event not queued");
`endif

endmodule
